### design/dq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Shared sizes, request and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_PUSH_LEFT  = 2'd0,
    REQ_PUSH_RIGHT = 2'd1,
    REQ_POP_LEFT   = 2'd2,
    REQ_POP_RIGHT  = 2'd3
  } dq_req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  // At most one of these is high in a cycle; each already includes the
  // request handshake and the full/empty check.
  typedef struct packed {
    logic push_left;
    logic push_right;
    logic pop_left;
    logic pop_right;
  } dq_cell_ctl_t;

endpackage

### design/dq_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// One storage slot of the shifting deque. Words sit packed from cell 0
// (left end) rightwards; each cell talks to its two neighbours and also sees the incoming word.
// ----------------------------------------------------------------------------
module dq_cell
  import dq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dq_cell_ctl_t          ctl,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_valid,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  right_valid,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  valid,
  output logic                  is_last
);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  valid_r, valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctl.push_left) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (ctl.push_right) begin
      // The first empty slot after the occupied run takes the new word.
      if (!valid_r && left_valid) begin
        data_nxt  = word;
        valid_nxt = 1'b1;
      end
    end else if (ctl.pop_left) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (ctl.pop_right) begin
      if (valid_r && !right_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign valid   = valid_r;
  assign is_last = valid_r && !right_valid;

endmodule

### design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Deque of signed words built as a row of shifting cells with a count.
// ----------------------------------------------------------------------------
// Each request pushes or pops a word at either end and yields one result in
// the next cycle: the popped word (zero otherwise), a status and the
// number of words held afterwards. A request is taken every cycle while the
// result register is empty or being drained in the same cycle; the single
// output register is what sets that rate. Popping an empty deque reports
// an empty error and pushing a full one reports a full error; neither
// changes the contents. All cells move together in the cycle a request is
// taken, so no request waits on another.
// ----------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_in
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] data_out, [36:32] count, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic                  cell_valid [DEPTH];
  logic                  cell_last  [DEPTH];

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_data_r, out_data_nxt;
  dq_status_t            out_status_r, out_status_nxt;
  logic [CNT_W-1:0]      out_count_r;

  logic                  accept;
  dq_req_t               req;
  logic [DATA_WIDTH-1:0] word;
  logic                  full;
  logic                  empty;
  logic [DATA_WIDTH-1:0] right_word;
  dq_cell_ctl_t          ctl;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign req       = dq_req_t'(in_tuser);
  assign word      = in_tdata[DATA_WIDTH-1:0];
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  always_comb begin
    ctl            = '0;
    out_data_nxt   = '0;
    out_status_nxt = ST_OK;
    count_nxt      = count_r;
    case (req)
      REQ_PUSH_LEFT, REQ_PUSH_RIGHT: begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          ctl.push_left  = accept && (req == REQ_PUSH_LEFT);
          ctl.push_right = accept && (req == REQ_PUSH_RIGHT);
          count_nxt      = count_r + CNT_W'(1);
        end
      end
      REQ_POP_LEFT: begin
        if (empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          ctl.pop_left = accept;
          out_data_nxt = cell_data[0];
          count_nxt    = count_r - CNT_W'(1);
        end
      end
      REQ_POP_RIGHT: begin
        if (empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          ctl.pop_right = accept;
          out_data_nxt  = right_word;
          count_nxt     = count_r - CNT_W'(1);
        end
      end
      default: begin
        out_status_nxt = ST_OK;
      end
    endcase
  end

  // At most one cell flags itself as the rightmost word; none does when empty.
  always_comb begin
    right_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      right_word = right_word | (cell_last[i] ? cell_data[i] : '0);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] l_data, r_data;
    logic                  l_valid, r_valid;

    if (g == 0) begin : g_left_end
      assign l_data  = word;
      assign l_valid = 1'b1;
    end else begin : g_left_mid
      assign l_data  = cell_data[g-1];
      assign l_valid = cell_valid[g-1];
    end

    if (g == DEPTH - 1) begin : g_right_end
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_right_mid
      assign r_data  = cell_data[g+1];
      assign r_valid = cell_valid[g+1];
    end

    dq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .word        (word),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[g]),
      .valid       (cell_valid[g]),
      .is_last     (cell_last[g])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_count_r, out_data_r};
  assign out_tuser  = out_status_r;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Deque testbench
// Drives push and pop requests at both ends of the deque, predicts every
// result with a shadow ring store and compares each returned word, status
// and count in order, under random idling on both sides of the stream.
// ----------------------------------------------------------------------------
module tb_top;
  import dq_pkg::*;

  typedef struct {
    dq_req_t                op;
    logic [DATA_WIDTH-1:0]  word;
  } deque_req_item_t;

  typedef struct {
    logic [DATA_WIDTH-1:0]  data;
    dq_status_t             status;
    logic [CNT_W-1:0]       count;
  } deque_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] data_in
  logic [1:0]  in_tuser = '0;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [31:0] data_out, [36:32] count, [39:37] zero
  logic [1:0]  out_tuser;       // [1:0] status

  deque_req_item_t pending_reqs[$];
  deque_req_item_t current_req;
  deque_result_t   awaited_results[$];

  // Shadow copy of the deque contents.
  logic [DATA_WIDTH-1:0] shadow_words [DEPTH];
  int shadow_head = 0;
  int shadow_tail = 0;
  int shadow_fill = 0;

  int  error_count = 0;
  int  results_seen = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  recv_hold = 0;
  bit  send_burst = 1'b0;
  bit  recv_burst = 1'b0;

  double_ended_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic deque_result_t deque_apply(input deque_req_item_t req);
    deque_result_t res;
    res.data   = '0;
    res.status = ST_OK;
    case (req.op)
      REQ_PUSH_LEFT, REQ_PUSH_RIGHT: begin
        if (shadow_fill == DEPTH) begin
          res.status = ST_FULL;
        end else if (req.op == REQ_PUSH_LEFT) begin
          shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
          shadow_words[shadow_head] = req.word;
          shadow_fill++;
        end else begin
          shadow_words[shadow_tail] = req.word;
          shadow_tail = (shadow_tail + 1) % DEPTH;
          shadow_fill++;
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else if (req.op == REQ_POP_LEFT) begin
          res.data = shadow_words[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_fill--;
        end else begin
          shadow_tail = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
          res.data = shadow_words[shadow_tail];
          shadow_fill--;
        end
      end
    endcase
    res.count = CNT_W'(shadow_fill);
    return res;
  endfunction

  // Idle cycles before the next request or result; bursts run with none.
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 99) < 2)
      burst = ~burst;
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_req(input dq_req_t op, input logic [DATA_WIDTH-1:0] word);
    deque_req_item_t item;
    item.op   = op;
    item.word = word;
    pending_reqs.push_back(item);
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        awaited_results.push_back(deque_apply(current_req));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          current_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= current_req.word;
          in_tuser  <= current_req.op;
          send_gap = draw_gap(send_burst);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver.
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result data=%h status=%0d count=%0d", $time,
                   out_tdata[31:0], out_tuser, out_tdata[36:32]);
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata[31:0] !== want.data) begin
            error_count++;
            $display("%0t: data_out mismatch, expected %h, actual %h", $time,
                     want.data, out_tdata[31:0]);
          end
          if (out_tuser !== want.status) begin
            error_count++;
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want.status, out_tuser);
          end
          if (out_tdata[36:32] !== want.count) begin
            error_count++;
            $display("%0t: count mismatch, expected %0d, actual %0d", $time,
                     want.count, out_tdata[36:32]);
          end
        end
        recv_gap = draw_gap(recv_burst);
        // Long hold-offs so that the output register fills and the input stalls.
        if (results_seen == 200 || results_seen == 900)
          recv_hold = 300;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int total;
    int seg_len;
    int push_pct;
    int item_total;
    // Empty pops at both ends, then the word extremes through both ends.
    queue_req(REQ_POP_LEFT, 32'hdead_beef);
    queue_req(REQ_POP_RIGHT, 32'h1234_5678);
    queue_req(REQ_PUSH_LEFT, 32'h7fff_ffff);
    queue_req(REQ_PUSH_RIGHT, 32'h8000_0000);
    queue_req(REQ_POP_LEFT, 32'h0);
    queue_req(REQ_POP_RIGHT, 32'hffff_ffff);
    // Fill to the brim from both sides so that the head pointer wraps, then push at both ends while full.
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: queue_req(REQ_PUSH_LEFT, 32'h8000_0000);
        1: queue_req(REQ_PUSH_RIGHT, 32'h7fff_ffff);
        2: queue_req(REQ_PUSH_LEFT, 32'hffff_ffff);
        default: queue_req(REQ_PUSH_RIGHT, 32'h0000_0000);
      endcase
    end
    queue_req(REQ_PUSH_LEFT, 32'h5555_5555);
    queue_req(REQ_PUSH_RIGHT, 32'haaaa_aaaa);

    // Random walks with a varying push bias, so that the deque swings
    // between full and empty many times.
    total = 0;
    while (total < 1600) begin
      seg_len  = $urandom_range(10, 60);
      push_pct = $urandom_range(10, 90);
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(0, 99) < push_pct)
          queue_req($urandom_range(0, 1) ? REQ_PUSH_RIGHT : REQ_PUSH_LEFT, pick_word());
        else
          queue_req($urandom_range(0, 1) ? REQ_POP_RIGHT : REQ_POP_LEFT, pick_word());
      end
      total += seg_len;
    end
    item_total = pending_reqs.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Every request yields exactly one result.
    while (results_seen < item_total)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && awaited_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### sim.f
design/dq_pkg.sv
design/dq_cell.sv
design/double_ended_queue.sv
tb/tb_top.sv
